FILE: src/mixing_matrix_generator_assert.svh
// Assertion macros for the mixing matrix generator checker.
`ifndef MIXING_MATRIX_GENERATOR_ASSERT_SVH
`define MIXING_MATRIX_GENERATOR_ASSERT_SVH

// Clocked check, masked while reset is asserted.
`define MMG_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("mixing matrix generator check failed");

// Clocked check that also runs through reset.
`define MMG_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("mixing matrix generator reset check failed");

`endif

FILE: src/mmg_pkg.sv
// Shared types, constants and arithmetic helpers of the mixing matrix generator.
package mmg_pkg;

    localparam int ANGLE_WIDTH = 16;
    localparam int OUT_WIDTH   = 16;
    localparam int OUT_FRAC    = OUT_WIDTH - 2;
    localparam int PHASE_W     = 32;
    localparam int VAL_W       = 34;
    localparam int OUT_SHIFT   = 30 - OUT_FRAC;
    localparam int NUM_ENTRIES = 9;

    // one full turn per 2^32, scaled by 2^28 / (2 pi)
    localparam logic [26:0] TURN_K = 27'd42722830;

    localparam logic [PHASE_W-1:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [31:0]        SIN_C0       = 32'd172272;

    localparam logic [2*VAL_W-1:0] ROUND_Q30 = (2*VAL_W)'(64'h2000_0000);
    localparam logic [VAL_W:0]     OUT_HALF  = (VAL_W+1)'(1) << (OUT_SHIFT - 1);
    localparam logic [VAL_W:0]     OUT_LIMIT = (VAL_W+1)'(1) << OUT_FRAC;

    typedef logic signed [VAL_W-1:0] t_val;

    typedef struct packed {
        logic signed [ANGLE_WIDTH-1:0] theta_12;
        logic signed [ANGLE_WIDTH-1:0] theta_13;
        logic signed [ANGLE_WIDTH-1:0] theta_23;
        logic signed [ANGLE_WIDTH-1:0] cp_phase;
        logic                          sign_select;
    } t_in_item;

    typedef struct packed {
        logic [1:0]                  row_index;
        logic [1:0]                  col_index;
        logic signed [OUT_WIDTH-1:0] real_part;
        logic signed [OUT_WIDTH-1:0] imag_part;
        logic                        last_entry;
    } t_out_item;

    typedef struct packed {
        logic [PHASE_W-1:0] p12;
        logic [PHASE_W-1:0] p13;
        logic [PHASE_W-1:0] p23;
        logic [PHASE_W-1:0] pd;
    } t_phase_set;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_TRIG,
        BK_PROD,
        BK_EMIT
    } t_back_state;

    // slots of the sine/cosine table, ordered as the trig sweep visits them
    localparam logic [2:0] T_S12 = 3'd0;
    localparam logic [2:0] T_C12 = 3'd1;
    localparam logic [2:0] T_S13 = 3'd2;
    localparam logic [2:0] T_C13 = 3'd3;
    localparam logic [2:0] T_S23 = 3'd4;
    localparam logic [2:0] T_C23 = 3'd5;
    localparam logic [2:0] T_SD  = 3'd6;
    localparam logic [2:0] T_CD  = 3'd7;

    // Horner coefficients of the quarter sine, Q30
    function automatic logic [31:0] horner_coef(input logic [2:0] k);
        logic [31:0] c;
        case (k)
            3'd1:    c = 32'd5026996;
            3'd2:    c = 32'd85569305;
            3'd3:    c = 32'd693598669;
            3'd4:    c = 32'd1686629713;
            default: c = 32'd0;
        endcase
        return c;
    endfunction

    // Q30 product rounded half away from zero
    function automatic t_val mul30(input t_val a, input t_val b);
        logic [VAL_W-1:0]   ua;
        logic [VAL_W-1:0]   ub;
        logic [2*VAL_W-1:0] pr;
        logic [VAL_W-1:0]   m;
        ua = a[VAL_W-1] ? VAL_W'(-a) : VAL_W'(a);
        ub = b[VAL_W-1] ? VAL_W'(-b) : VAL_W'(b);
        pr = ua * ub;
        pr = pr + ROUND_Q30;
        m  = pr[30 +: VAL_W];
        return (a[VAL_W-1] ^ b[VAL_W-1]) ? t_val'(-m) : t_val'(m);
    endfunction

    // Q30 to output format: round half away from zero, saturate at one
    function automatic logic signed [OUT_WIDTH-1:0] to_out(input t_val v);
        logic [VAL_W-1:0] mag;
        logic [VAL_W:0]   rnd;
        mag = v[VAL_W-1] ? VAL_W'(-v) : VAL_W'(v);
        rnd = ({1'b0, mag} + OUT_HALF) >> OUT_SHIFT;
        if (rnd > OUT_LIMIT) begin
            rnd = OUT_LIMIT;
        end
        return v[VAL_W-1] ? OUT_WIDTH'(-rnd) : OUT_WIDTH'(rnd);
    endfunction

endpackage

FILE: src/mmg_fifo.sv
// Small synchronous queue with registered storage and occupancy count.
module mmg_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_cnt == CNT_W'(DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign o_data    = r_mem[r_rd];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_do_pop && !w_do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

FILE: src/mmg_front.sv
// Front end: takes input beats and turns the angles into turn phases.
module mmg_front
    import mmg_pkg::*;
(
    input  logic       push,
    input  t_in_item   i_item,
    input  logic       i_q_full,
    output logic       o_full,
    output logic       o_q_push,
    output t_phase_set o_phases
);

    localparam int PROD_W = ANGLE_WIDTH + 28;

    // phase = round(angle * K / 2^8), kept modulo one turn
    function automatic logic [PHASE_W-1:0] to_phase(input logic signed [ANGLE_WIDTH-1:0] a);
        logic signed [PROD_W-1:0] pr;
        pr = PROD_W'(a) * PROD_W'(signed'({1'b0, TURN_K}));
        pr = pr + PROD_W'(128);
        return pr[39:8];
    endfunction

    logic [PHASE_W-1:0] w_pd;

    assign o_full   = i_q_full;
    assign o_q_push = push && !i_q_full;

    always_comb begin
        w_pd         = to_phase(i_item.cp_phase);
        o_phases.p12 = to_phase(i_item.theta_12);
        o_phases.p13 = to_phase(i_item.theta_13);
        o_phases.p23 = to_phase(i_item.theta_23);
        // antiparticle: flip the phase modulo one turn
        o_phases.pd  = i_item.sign_select ? (~w_pd + 1'b1) : w_pd;
    end

endmodule

FILE: src/mmg_back.sv
// Back end: sine/cosine sweep, entry products and result emission.
module mmg_back
    import mmg_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_empty,
    input  t_phase_set i_phases,
    output logic       o_q_pop,
    input  logic       i_out_full,
    output logic       o_out_push,
    output t_out_item  o_out_item
);

    localparam logic [2:0] K_LAST    = 3'd5;
    localparam logic [4:0] STEP_LAST = 5'd25;
    localparam logic [4:0] EMIT_LAST = 5'(NUM_ENTRIES - 1);

    function automatic logic [1:0] row_of(input logic [3:0] k);
        logic [1:0] r;
        case (k)
            4'd0, 4'd3, 4'd6: r = 2'd0;
            4'd1, 4'd4, 4'd7: r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] col_of(input logic [3:0] k);
        logic [1:0] c;
        case (k)
            4'd0, 4'd1, 4'd2: c = 2'd0;
            4'd3, 4'd4, 4'd5: c = 2'd1;
            default:          c = 2'd2;
        endcase
        return c;
    endfunction

    t_back_state r_state, n_state;
    logic [2:0]  r_idx, n_idx;
    logic [2:0]  r_k, n_k;
    logic [4:0]  r_step, n_step;

    t_phase_set  r_ph, n_ph;
    logic [30:0] r_z, n_z;
    logic [30:0] r_z2, n_z2;
    logic [31:0] r_s, n_s;
    logic        r_neg, n_neg;
    t_val        r_trig [8];
    t_val        n_trig [8];
    t_val        r_u, n_u;
    t_val        r_t, n_t;
    t_val        r_a, n_a;
    t_val        r_re [NUM_ENTRIES];
    t_val        n_re [NUM_ENTRIES];
    t_val        r_im [NUM_ENTRIES];
    t_val        n_im [NUM_ENTRIES];

    logic [PHASE_W-1:0] w_base;
    logic [PHASE_W-1:0] w_ph;
    logic [30:0]        w_z;
    logic [31:0]        w_opa;
    logic [31:0]        w_opb;
    logic [63:0]        w_tprod;
    logic [31:0]        w_tsh;
    t_val               w_pa;
    t_val               w_pb;
    t_val               w_m;

    // phase of the current trig slot; odd slots are cosines (a quarter turn on)
    always_comb begin
        case (r_idx[2:1])
            2'd0:    w_base = r_ph.p12;
            2'd1:    w_base = r_ph.p13;
            2'd2:    w_base = r_ph.p23;
            default: w_base = r_ph.pd;
        endcase
        w_ph = w_base + (r_idx[0] ? QUARTER_TURN : '0);
        w_z  = w_ph[30] ? (31'(QUARTER_TURN) - {1'b0, w_ph[29:0]}) : {1'b0, w_ph[29:0]};
    end

    // shared unsigned multiplier of the polynomial
    always_comb begin
        if (r_k == '0) begin
            w_opa = {1'b0, w_z};
            w_opb = {1'b0, w_z};
        end else if (r_k == K_LAST) begin
            w_opa = r_s;
            w_opb = {1'b0, r_z};
        end else begin
            w_opa = r_s;
            w_opb = {1'b0, r_z2};
        end
        w_tprod = w_opa * w_opb;
        w_tsh   = w_tprod[61:30];
    end

    // operand pick of the entry products
    always_comb begin
        case (r_step)
            5'd0:    begin w_pa = r_trig[T_C12]; w_pb = r_trig[T_C13]; end
            5'd1:    begin w_pa = r_trig[T_S12]; w_pb = r_trig[T_C13]; end
            5'd2:    begin w_pa = r_trig[T_S13]; w_pb = r_trig[T_CD];  end
            5'd3:    begin w_pa = r_trig[T_S13]; w_pb = r_trig[T_SD];  end
            5'd4:    begin w_pa = r_trig[T_C12]; w_pb = r_trig[T_S23]; end
            5'd6:    begin w_pa = r_trig[T_S12]; w_pb = r_trig[T_C23]; end
            5'd9:    begin w_pa = r_trig[T_S12]; w_pb = r_trig[T_S23]; end
            5'd11:   begin w_pa = r_trig[T_C12]; w_pb = r_trig[T_C23]; end
            5'd14:   begin w_pa = r_trig[T_S23]; w_pb = r_trig[T_C13]; end
            5'd15:   begin w_pa = r_trig[T_C12]; w_pb = r_trig[T_C23]; end
            5'd17:   begin w_pa = r_trig[T_S12]; w_pb = r_trig[T_S23]; end
            5'd20:   begin w_pa = r_trig[T_S12]; w_pb = r_trig[T_C23]; end
            5'd22:   begin w_pa = r_trig[T_C12]; w_pb = r_trig[T_S23]; end
            5'd25:   begin w_pa = r_trig[T_C23]; w_pb = r_trig[T_C13]; end
            5'd5, 5'd10, 5'd16, 5'd21: begin
                w_pa = r_u;
                w_pb = r_trig[T_S13];
            end
            5'd7, 5'd12, 5'd18, 5'd23: begin
                w_pa = r_t;
                w_pb = r_trig[T_CD];
            end
            default: begin
                w_pa = r_t;
                w_pb = r_trig[T_SD];
            end
        endcase
        w_m = mul30(w_pa, w_pb);
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_k     = r_k;
        n_step  = r_step;
        n_ph    = r_ph;
        n_z     = r_z;
        n_z2    = r_z2;
        n_s     = r_s;
        n_neg   = r_neg;
        n_trig  = r_trig;
        n_u     = r_u;
        n_t     = r_t;
        n_a     = r_a;
        n_re    = r_re;
        n_im    = r_im;

        o_q_pop    = 1'b0;
        o_out_push = 1'b0;

        o_out_item.row_index  = row_of(r_step[3:0]);
        o_out_item.col_index  = col_of(r_step[3:0]);
        o_out_item.real_part  = to_out(r_re[r_step[3:0]]);
        o_out_item.imag_part  = to_out(r_im[r_step[3:0]]);
        o_out_item.last_entry = (r_step == EMIT_LAST);

        case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_ph    = i_phases;
                    n_idx   = '0;
                    n_k     = '0;
                    n_state = BK_TRIG;
                end
            end
            BK_TRIG: begin
                if (r_k == '0) begin
                    n_z   = w_z;
                    n_neg = w_ph[31];
                    n_z2  = w_tsh[30:0];
                    n_s   = SIN_C0;
                end else if (r_k == K_LAST) begin
                    n_trig[r_idx] = r_neg ? -t_val'({2'b00, w_tsh}) : t_val'({2'b00, w_tsh});
                end else begin
                    n_s = horner_coef(r_k) - w_tsh;
                end
                if (r_k == K_LAST) begin
                    n_k = '0;
                    if (r_idx == T_CD) begin
                        n_step  = '0;
                        n_state = BK_PROD;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            BK_PROD: begin
                case (r_step)
                    5'd0:  begin n_re[0] = w_m; n_im[0] = '0; end
                    5'd1:  begin n_re[3] = w_m; n_im[3] = '0; end
                    5'd2:  n_re[6] = w_m;
                    5'd3:  n_im[6] = -w_m;
                    5'd7:  n_re[1] = -r_a - w_m;
                    5'd8:  n_im[1] = -w_m;
                    5'd12: n_re[4] = r_a - w_m;
                    5'd13: n_im[4] = -w_m;
                    5'd14: begin n_re[7] = w_m; n_im[7] = '0; end
                    5'd18: n_re[2] = r_a - w_m;
                    5'd19: n_im[2] = -w_m;
                    5'd23: n_re[5] = -r_a - w_m;
                    5'd24: n_im[5] = -w_m;
                    5'd25: begin n_re[8] = w_m; n_im[8] = '0; end
                    5'd4, 5'd9, 5'd15, 5'd20: n_u = w_m;
                    5'd5, 5'd10, 5'd16, 5'd21: n_t = w_m;
                    5'd6, 5'd11, 5'd17, 5'd22: n_a = w_m;
                    default: n_a = r_a;
                endcase
                if (r_step == STEP_LAST) begin
                    n_step  = '0;
                    n_state = BK_EMIT;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            BK_EMIT: begin
                if (!i_out_full) begin
                    o_out_push = 1'b1;
                    if (r_step == EMIT_LAST) begin
                        n_step  = '0;
                        n_state = BK_IDLE;
                    end else begin
                        n_step = r_step + 1'b1;
                    end
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_idx   <= '0;
            r_k     <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_k     <= n_k;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ph   <= n_ph;
        r_z    <= n_z;
        r_z2   <= n_z2;
        r_s    <= n_s;
        r_neg  <= n_neg;
        r_trig <= n_trig;
        r_u    <= n_u;
        r_t    <= n_t;
        r_a    <= n_a;
        r_re   <= n_re;
        r_im   <= n_im;
    end

endmodule

FILE: src/mixing_matrix_generator.sv
// Top level of the mixing matrix generator: front end, phase queue, back end, result queue.
// The back end's single sequencer takes a new item only once its last result beat is out;
//   per item: pick-up, 8 sine/cosine slots x 6 multiply steps, 26 entry products, 9 result beats.
// Result beats follow the trig sweep and the entry products; emission stalls while
//   the result queue is full.
// Reset (i_rst_n low, synchronous): both queues empty, back end idle; full and empty
//   show the empty block on the next cycle.
module mixing_matrix_generator
    import mmg_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_item
);

    // two items may wait between the front end and the back end
    localparam int PHASE_Q_DEPTH = 2;
    // result queue decouples emission from a stalled consumer
    localparam int OUT_Q_DEPTH   = 2;

    logic       w_pq_full;
    logic       w_pq_empty;
    logic       w_pq_push;
    logic       w_pq_pop;
    t_phase_set w_pq_in;
    t_phase_set w_pq_out;
    logic [$bits(t_phase_set)-1:0] w_pq_out_bits;

    logic       w_oq_full;
    logic       w_oq_push;
    t_out_item  w_oq_in;
    logic [$bits(t_out_item)-1:0] w_oq_out_bits;

    // Convert angles to phases and drop them in the phase queue.
    mmg_front u_front (
        .push     (push),
        .i_item   (i_item),
        .i_q_full (w_pq_full),
        .o_full   (full),
        .o_q_push (w_pq_push),
        .o_phases (w_pq_in)
    );

    mmg_fifo #(
        .WIDTH ($bits(t_phase_set)),
        .DEPTH (PHASE_Q_DEPTH)
    ) u_phase_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_pq_push),
        .i_data  (w_pq_in),
        .i_pop   (w_pq_pop),
        .o_data  (w_pq_out_bits),
        .o_full  (w_pq_full),
        .o_empty (w_pq_empty)
    );

    assign w_pq_out = t_phase_set'(w_pq_out_bits);

    // Hold each item through the trig sweep and products, then emit nine beats.
    mmg_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (w_pq_empty),
        .i_phases   (w_pq_out),
        .o_q_pop    (w_pq_pop),
        .i_out_full (w_oq_full),
        .o_out_push (w_oq_push),
        .o_out_item (w_oq_in)
    );

    mmg_fifo #(
        .WIDTH ($bits(t_out_item)),
        .DEPTH (OUT_Q_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_oq_push),
        .i_data  (w_oq_in),
        .i_pop   (pop),
        .o_data  (w_oq_out_bits),
        .o_full  (w_oq_full),
        .o_empty (empty)
    );

    // Advance the oldest result onto the ports.
    assign o_item = t_out_item'(w_oq_out_bits);

endmodule

FILE: src/mmg_checker.sv
// Port-level checks of the mixing matrix generator and their binding.
`include "mixing_matrix_generator_assert.svh"

module mmg_checker
    import mmg_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      full,
    input logic      empty,
    input logic      pop,
    input t_out_item o_item
);

    `MMG_ASSERT(a_row_in_range, !empty |-> o_item.row_index != 2'd3 && o_item.col_index != 2'd3)
    `MMG_ASSERT(a_last_is_corner, !empty && o_item.last_entry |-> o_item.row_index == 2'd2 && o_item.col_index == 2'd2)
    `MMG_ASSERT(a_first_entry_real, !empty && o_item.row_index == 2'd0 && o_item.col_index == 2'd0 |-> o_item.imag_part == '0)
    `MMG_ASSERT(a_stall_keeps_beat, !empty && !pop |=> !empty)
    `MMG_ASSERT_RST(a_reset_empties, !i_rst_n |=> empty && !full)

endmodule

bind mixing_matrix_generator mmg_checker u_checker (.*);
